// File: design/mlhb_pkg.sv
// Shared types, constants and TID group encoder for the mesh layer-2 header builder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mlhb_pkg;

  localparam int unsigned MaxPayloadDefault = 128;
  localparam int unsigned PayloadW          = 10;
  localparam int unsigned TidW              = 32;
  localparam int unsigned AlgoW             = 3;
  localparam int unsigned ProtoW            = 4;
  localparam int unsigned HdrBytes          = 12;
  localparam int unsigned TidBytes          = 5;
  localparam int unsigned IdxW              = 4;
  localparam int unsigned InDataW           = 88;
  localparam int unsigned CfgIdxW           = 8;
  localparam int unsigned CfgDataW          = 32;

  localparam logic [AlgoW-1:0] AlgoNoneRst    = 3'd0;
  localparam logic [AlgoW-1:0] AlgoVerifyRst  = 3'd1;
  localparam logic [AlgoW-1:0] AlgoAuthEncRst = 3'd2;

  localparam logic [7:0] ExtBit   = 8'h80;
  localparam logic [7:0] BcastBit = 8'h40;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_VERIFY   = 2'd1,
    KIND_AUTH_ENC = 2'd2,
    KIND_INVALID  = 2'd3
  } sec_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNROUTABLE = 2'd1,
    ST_MALFORMED  = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_TID      = 8'd0,
    REG_ALGO_NONE    = 8'd1,
    REG_ALGO_VERIFY  = 8'd2,
    REG_ALGO_AUTHENC = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TidW-1:0]  own_tid;
    logic [AlgoW-1:0] algo_none;
    logic [AlgoW-1:0] algo_verify;
    logic [AlgoW-1:0] algo_auth_enc;
  } cfg_t;

  typedef struct packed {
    logic [HdrBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
    status_t                  status;
  } hdr_t;

  typedef struct packed {
    logic [TidBytes-1:0][7:0] b;
    logic [2:0]               n;
  } tid_enc_t;

  // Big-endian 7-bit groups, leading zero groups dropped, last group always kept.
  function automatic tid_enc_t tid_encode(input logic [TidW-1:0] tid);
    logic [34:0] t;
    tid_enc_t    r;
    int          g;
    t   = {3'b000, tid};
    r.n = 3'd1;
    r.b = '0;
    for (int k = 1; k < TidBytes; k++) begin
      if (t[7*k +: 7] != 7'd0) begin
        r.n = 3'(k + 1);
      end
    end
    for (int k = 0; k < TidBytes; k++) begin
      if (k < int'(r.n)) begin
        g = int'(r.n) - 1 - k;
        r.b[k] = {(g != 0), t[7*g +: 7]};
      end
    end
    return r;
  endfunction

endpackage

// File: design/mlhb_build.sv
// Header assembly logic: checks one request and lays out its header bytes.
// Depends on mlhb_pkg.
`timescale 1ns / 1ps

module mlhb_build #(
  parameter int unsigned MAX_PAYLOAD = mlhb_pkg::MaxPayloadDefault
) (
  input  logic [1:0]                    security_kind,
  input  logic [mlhb_pkg::ProtoW-1:0]   l3_protocol,
  input  logic                          broadcast,
  input  logic [mlhb_pkg::TidW-1:0]     dest_tid,
  input  logic [mlhb_pkg::TidW-1:0]     src_tid,
  input  logic [mlhb_pkg::PayloadW-1:0] payload_len,
  input  mlhb_pkg::cfg_t                cfg,
  output mlhb_pkg::hdr_t                hdr
);

  localparam logic [mlhb_pkg::PayloadW-1:0] MaxLen = mlhb_pkg::PayloadW'(MAX_PAYLOAD);

  logic [mlhb_pkg::AlgoW-1:0] algo;
  logic                       kind_bad;
  logic [mlhb_pkg::TidW-1:0]  stid;
  logic [7:0]                 b1;
  logic [7:0]                 b2;
  mlhb_pkg::tid_enc_t         denc;
  mlhb_pkg::tid_enc_t         senc;
  logic [mlhb_pkg::IdxW-1:0]  nc;
  logic [mlhb_pkg::IdxW-1:0]  nd;
  logic [mlhb_pkg::IdxW-1:0]  ns;

  always_comb begin
    kind_bad = 1'b0;
    case (mlhb_pkg::sec_kind_t'(security_kind))
      mlhb_pkg::KIND_NONE:     algo = cfg.algo_none;
      mlhb_pkg::KIND_VERIFY:   algo = cfg.algo_verify;
      mlhb_pkg::KIND_AUTH_ENC: algo = cfg.algo_auth_enc;
      default: begin
        algo     = '0;
        kind_bad = 1'b1;
      end
    endcase
  end

  assign stid = (src_tid == '0) ? cfg.own_tid : src_tid;
  assign b2   = {1'b0, algo[2], 4'b0000, l3_protocol[3:2]};
  assign b1   = ((b2 != 8'd0) ? mlhb_pkg::ExtBit : 8'd0)
              | (broadcast ? mlhb_pkg::BcastBit : 8'd0)
              | {2'b00, algo[1:0], l3_protocol[1:0], 2'b00};
  assign denc = mlhb_pkg::tid_encode(dest_tid);
  assign senc = mlhb_pkg::tid_encode(stid);
  assign nc   = (b2 != 8'd0) ? 4'd2 : 4'd1;
  assign nd   = broadcast ? 4'd0 : {1'b0, denc.n};
  assign ns   = {1'b0, senc.n};

  always_comb begin
    hdr = '0;
    if (kind_bad || stid == '0) begin
      hdr.status = mlhb_pkg::ST_UNROUTABLE;
    end else if ((dest_tid == '0 && !broadcast) || payload_len > MaxLen) begin
      hdr.status = mlhb_pkg::ST_MALFORMED;
    end else begin
      hdr.status   = mlhb_pkg::ST_OK;
      hdr.last_idx = nc + nd + ns - 4'd1;
      for (int j = 0; j < mlhb_pkg::HdrBytes; j++) begin
        if (j == 0) begin
          hdr.bytes[j] = b1;
        end else if (j < int'(nc)) begin
          hdr.bytes[j] = b2;
        end else if (j < int'(nc) + int'(nd)) begin
          hdr.bytes[j] = denc.b[3'(j - int'(nc))];
        end else if (j < int'(nc) + int'(nd) + int'(ns)) begin
          hdr.bytes[j] = senc.b[3'(j - int'(nc) - int'(nd))];
        end
      end
    end
  end

endmodule

// File: design/mlhb_ser.sv
// Header register and byte serializer: holds one built header and sends it a byte a transfer.
// Depends on mlhb_pkg.
`timescale 1ns / 1ps

module mlhb_ser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  mlhb_pkg::hdr_t hdr_in,
  output logic           ready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic [1:0]     out_tuser
);

  logic                      valid_r, valid_nxt;
  logic [mlhb_pkg::IdxW-1:0] idx_r, idx_nxt;
  mlhb_pkg::hdr_t            hdr_r, hdr_nxt;
  logic                      xfer;
  logic                      done;

  assign xfer  = valid_r & out_tready;
  assign done  = xfer & (idx_r == hdr_r.last_idx);
  assign ready = ~valid_r | done;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    hdr_nxt   = hdr_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
      hdr_nxt   = hdr_in;
    end else if (done) begin
      valid_nxt = 1'b0;
    end else if (xfer) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
    hdr_r <= hdr_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = hdr_r.bytes[idx_r];
  assign out_tlast  = (idx_r == hdr_r.last_idx);
  assign out_tuser  = hdr_r.status;

endmodule

// File: design/mesh_l2_header_builder.sv
// Mesh layer-2 header builder top level: configuration registers, header assembly, serializer.
// Depends on mlhb_pkg, mlhb_build and mlhb_ser.
`timescale 1ns / 1ps

// A request is built into a complete header in the cycle it is accepted and
// leaves as one byte per output transfer: 2 to 12 bytes for a good request,
// a single zero byte with tlast and an error status otherwise. The next
// request is taken in the same cycle the last byte of the previous one
// transfers, so back-pressure on the output alone sets throughput.
// Configuration writes are always accepted and take effect for the next request.
module mesh_l2_header_builder #(
  parameter int unsigned MAX_PAYLOAD = mlhb_pkg::MaxPayloadDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // security_kind[1:0], l3_protocol[5:2], broadcast[6], dest_tid[38:7],
  // src_tid[70:39], payload_len[80:71], zero fill[87:81]
  input  logic [mlhb_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_byte[7:0]
  output logic [7:0]                    out_tdata,
  output logic                          out_tlast,
  // status[1:0]
  output logic [1:0]                    out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mlhb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mlhb_pkg::CfgDataW-1:0] cfg_data
);

  mlhb_pkg::cfg_t cfg_r, cfg_nxt;
  mlhb_pkg::hdr_t hdr;
  logic           load;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (mlhb_pkg::reg_idx_t'(cfg_index))
        mlhb_pkg::REG_OWN_TID:      cfg_nxt.own_tid       = cfg_data;
        mlhb_pkg::REG_ALGO_NONE:    cfg_nxt.algo_none     = cfg_data[2:0];
        mlhb_pkg::REG_ALGO_VERIFY:  cfg_nxt.algo_verify   = cfg_data[2:0];
        mlhb_pkg::REG_ALGO_AUTHENC: cfg_nxt.algo_auth_enc = cfg_data[2:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_tid       <= '0;
      cfg_r.algo_none     <= mlhb_pkg::AlgoNoneRst;
      cfg_r.algo_verify   <= mlhb_pkg::AlgoVerifyRst;
      cfg_r.algo_auth_enc <= mlhb_pkg::AlgoAuthEncRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mlhb_build #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_build (
    .security_kind(in_tdata[1:0]),
    .l3_protocol  (in_tdata[5:2]),
    .broadcast    (in_tdata[6]),
    .dest_tid     (in_tdata[38:7]),
    .src_tid      (in_tdata[70:39]),
    .payload_len  (in_tdata[80:71]),
    .cfg          (cfg_r),
    .hdr          (hdr)
  );

  assign load = in_tvalid & in_tready;

  mlhb_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .hdr_in    (hdr),
    .ready     (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// File: design/mlhb_checker.sv
// Port-level checks for the mesh layer-2 header builder, bound to the top level.
// Depends on mlhb_pkg and mesh_l2_header_builder.
`timescale 1ns / 1ps

module mlhb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != mlhb_pkg::ST_OK) |-> (out_tlast && out_tdata == 8'd0))
    else $error("error result is not a single zero byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == mlhb_pkg::ST_OK || out_tuser == mlhb_pkg::ST_UNROUTABLE ||
                    out_tuser == mlhb_pkg::ST_MALFORMED))
    else $error("undefined status code");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !(out_tlast && out_tready)) |-> !in_tready)
    else $error("input taken while header still pending");

  a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled output changed");

endmodule

bind mesh_l2_header_builder mlhb_checker u_mlhb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
